/* rtl/mtps_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mtps_pkg
// Shared types and codes for the maze turn path simplifier.
// ----------------------------------------------------------------------------
package mtps_pkg;

  // Operation codes carried on the input channel.
  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  // Turn symbols as stored in the path memory.
  typedef enum logic [1:0] {
    TURN_L = 2'd0,
    TURN_S = 2'd1,
    TURN_R = 2'd2,
    TURN_U = 2'd3
  } turn_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  // Controller states.
  typedef enum logic {
    CS_IDLE = 1'b0,
    CS_EXEC = 1'b1
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic issue;   // Capture the operation and start the memory access.
    logic retire;  // Finish the operation and load the result register.
  } ctrl_cmd_t;

endpackage : mtps_pkg
`default_nettype wire

/* rtl/mtps_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mtps_ctrl
// Two-state sequencer and output valid flag for the path simplifier.
// ----------------------------------------------------------------------------
module mtps_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output mtps_pkg::ctrl_cmd_t     cmd_o
);
  import mtps_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= CS_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    out_valid_d  = out_valid_q;
    in_ready_o   = 1'b0;
    cmd_o.issue  = 1'b0;
    cmd_o.retire = 1'b0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      CS_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.issue = in_valid_i;
        if (in_valid_i) begin
          state_d = CS_EXEC;
        end
      end
      CS_EXEC: begin
        // The result waits here until the output register is free.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.retire = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = CS_IDLE;
        end
      end
      default: begin
        state_d = CS_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule : mtps_ctrl
`default_nettype wire

/* rtl/mtps_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mtps_datapath
// Path memory, length counter, cached top entry and result register.
// ----------------------------------------------------------------------------
module mtps_datapath #(
  parameter int PATH_DEPTH = 256
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire mtps_pkg::ctrl_cmd_t cmd_i,
  input  wire logic [1:0]          op_i,
  input  wire logic [1:0]          turn_i,
  input  wire logic [7:0]          index_i,
  output logic [8:0]               path_length_o,
  output logic [1:0]               entry_o,
  output logic [1:0]               status_o
);
  import mtps_pkg::*;

  localparam int AW = (PATH_DEPTH > 1) ? $clog2(PATH_DEPTH) : 1;
  localparam int CW = $clog2(PATH_DEPTH + 1);
  localparam int IW = (CW > 8) ? CW : 8;

  logic [1:0]    mem [PATH_DEPTH];

  logic [CW-1:0] count_q, count_d;
  logic [1:0]    top_q, top_d;
  logic [1:0]    op_q, turn_q, rdata_q;
  logic          full_q, hit_q;
  logic [8:0]    path_length_q, path_length_d;
  logic [1:0]    entry_q, entry_d;
  logic [1:0]    status_q, status_d;

  logic [IW-1:0] idx_ext, cnt_ext;
  logic [AW-1:0] rd_addr, wr_addr;
  logic          wr_en;
  logic [1:0]    wr_data;
  logic          full_now;
  logic [1:0]    sum_qt, merged;

  // Turn code to quarter turns (S=0, R=1, U=2, L=3) and back.
  function automatic logic [1:0] quarters_of(input logic [1:0] code);
    return code + 2'd3;
  endfunction

  function automatic logic [1:0] code_of(input logic [1:0] quarters);
    return quarters + 2'd1;
  endfunction

  assign idx_ext  = IW'(index_i);
  assign cnt_ext  = IW'(count_q);
  assign full_now = (count_q == CW'(PATH_DEPTH));
  assign rd_addr  = (op_i == OP_READ) ? AW'(idx_ext) : AW'(count_q - CW'(2));

  // The top entry is always a U-turn when a collapse happens.
  assign sum_qt = quarters_of(turn_q) + quarters_of(TURN_U) + quarters_of(rdata_q);
  assign merged = code_of(sum_qt);

  always_comb begin
    count_d       = count_q;
    top_d         = top_q;
    path_length_d = path_length_q;
    entry_d       = entry_q;
    status_d      = status_q;
    wr_en         = 1'b0;
    wr_addr       = AW'(count_q);
    wr_data       = turn_i;
    if (cmd_i.issue && (op_i == OP_PUSH) && !full_now) begin
      wr_en = 1'b1;
    end
    if (cmd_i.retire) begin
      entry_d  = TURN_L;
      status_d = ST_OK;
      case (op_q)
        OP_PUSH: begin
          if (full_q) begin
            status_d = ST_FULL;
          end else if ((count_q >= CW'(2)) && (top_q == TURN_U)) begin
            wr_en   = 1'b1;
            wr_addr = AW'(count_q - CW'(2));
            wr_data = merged;
            count_d = count_q - CW'(1);
            top_d   = merged;
          end else begin
            count_d = count_q + CW'(1);
            top_d   = turn_q;
          end
        end
        OP_READ: begin
          if (hit_q) begin
            entry_d = rdata_q;
          end else begin
            status_d = ST_RANGE;
          end
        end
        OP_CLEAR: begin
          count_d = '0;
        end
        default: begin
          count_d = count_q;
        end
      endcase
      path_length_d = 9'(count_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      op_q    <= op_i;
      turn_q  <= turn_i;
      full_q  <= full_now;
      hit_q   <= (idx_ext < cnt_ext);
      rdata_q <= mem[rd_addr];
    end
    top_q         <= top_d;
    path_length_q <= path_length_d;
    entry_q       <= entry_d;
    status_q      <= status_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  assign path_length_o = path_length_q;
  assign entry_o       = entry_q;
  assign status_o      = status_q;

endmodule : mtps_datapath
`default_nettype wire

/* rtl/maze_turn_path_simplifier_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// maze_turn_path_simplifier_core
// Stack of maze turns that collapses a turn, U-turn, turn triple on push.
//
//   Channel  Direction  Handshake               Payload
//   in       input      in_valid_i/in_ready_o   op_i, turn_i, index_i
//   out      output     out_valid_o/out_ready_i path_length_o, entry_o, status_o
//
// On acceptance a pushed turn is written and one registered read of the path
// memory is issued; the operation completes in the execute state, where a
// collapsed turn is written back and the result register is loaded. A finished
// result sits in the output register; the next transfer on the input side may
// be taken while it waits, but that operation stalls in the execute state until
// the output register frees up, and the input is not ready in the meantime.
// Reset empties the path; the memory itself is not cleared.
// ----------------------------------------------------------------------------
module maze_turn_path_simplifier_core #(
  parameter int PATH_DEPTH = 256
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [1:0] op_i,
  input  wire logic [1:0] turn_i,
  input  wire logic [7:0] index_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [8:0]      path_length_o,
  output logic [1:0]      entry_o,
  output logic [1:0]      status_o
);
  import mtps_pkg::*;

  // Commands from the sequencer: issue on the input transfer, retire when
  // the result is loaded into the output register.
  ctrl_cmd_t cmd;

  mtps_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // The datapath holds the path memory, the length, a copy of the top entry
  // so that a push needs only one memory read, and the result register.
  mtps_datapath #(
    .PATH_DEPTH (PATH_DEPTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .op_i          (op_i),
    .turn_i        (turn_i),
    .index_i       (index_i),
    .path_length_o (path_length_o),
    .entry_o       (entry_o),
    .status_o      (status_o)
  );

endmodule : maze_turn_path_simplifier_core
`default_nettype wire
